>>> rtl/pmd_pkg.sv
// Shared types, constants and helpers of the pose message deframer.
package pmd_pkg;

    // Widest slot mask any configuration can need (slot field is 4 bits)
    localparam int SLOT_LIMIT = 16;
    localparam int WORD_COUNT = 7;

    // Descriptor queue between parser and emitter
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Header bytes and message types
    localparam logic [7:0] HDR_MAGIC0  = 8'h56;
    localparam logic [7:0] HDR_MAGIC1  = 8'h50;
    localparam logic [7:0] TYPE_POSE   = 8'h01;
    localparam logic [7:0] TYPE_RESET  = 8'h02;
    localparam logic [7:0] TYPE_ORIGIN = 8'h03;

    // Body lengths in bytes, and the index of the last header byte
    localparam logic [4:0] RECORD_BYTES  = 5'd29;
    localparam logic [4:0] PAYLOAD_BYTES = 5'd28;
    localparam logic [4:0] HEADER_LAST   = 5'd3;

    typedef enum logic [1:0] {
        KIND_UPDATE     = 2'd0,
        KIND_INVALIDATE = 2'd1,
        KIND_ORIGIN     = 2'd2
    } kind_t;

    typedef logic [SLOT_LIMIT-1:0]            mask_t;
    typedef logic [WORD_COUNT-1:0][31:0]      words_t;

    // Everything one input byte asks the emitter to send, in send order:
    // update first, then invalidates by ascending slot, then origin.
    typedef struct packed {
        logic       upd;
        logic [3:0] upd_slot;
        mask_t      inv;
        logic       origin;
        words_t     words;
    } desc_t;

    // Index of the lowest set bit; zero for an empty mask
    function automatic logic [3:0] lowest_index(input mask_t m);
        logic [3:0] idx;
        idx = '0;
        for (int i = SLOT_LIMIT - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                idx = 4'(i);
            end
        end
        return idx;
    endfunction

endpackage

>>> rtl/pmd_stream_if.sv
// Valid/ready channel interfaces for the byte input and the event output.
interface pmd_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] byte_value;

    modport source (output valid, mode, byte_value, input ready);
    modport sink   (input valid, mode, byte_value, output ready);
endinterface

interface pmd_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  slot;
    logic [1:0]  event_kind;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] rot_w;
    logic [31:0] rot_x;
    logic [31:0] rot_y;
    logic [31:0] rot_z;
    logic        last;

    modport source (output valid, slot, event_kind, pos_x, pos_y, pos_z,
                    rot_w, rot_x, rot_y, rot_z, last, input ready);
    modport sink   (input valid, slot, event_kind, pos_x, pos_y, pos_z,
                    rot_w, rot_x, rot_y, rot_z, last, output ready);
endinterface

>>> rtl/pose_message_deframer.sv
// Top level of the pose message deframer.
// Accepts one stream byte (or a link-closed request) per cycle whenever the
// four-entry descriptor queue has room; each request is framed as it is
// accepted and yields zero to MAX_SLOTS+1 events, which leave one per cycle
// while the sink is ready from a registered output, after passing the queue
// and the working descriptor. The emitter's rate of one event per cycle sets
// the sustained figure: input stalls only while the queue is full, which
// happens when a burst of invalidates (a batch end, reset-all, set-origin or
// link close) or a slow event sink outpaces the drain. The last flag marks
// the final event caused by one input request. No clearing pass after reset.
module pose_message_deframer #(
    parameter int MAX_SLOTS = 9
) (
    input  logic      clk,
    input  logic      rst_n,
    pmd_in_if.sink    in_bytes,
    pmd_out_if.source events
);

    logic           push;
    logic           q_full;
    pmd_pkg::desc_t wr_desc;
    logic           q_valid;
    logic           q_pop;
    pmd_pkg::desc_t rd_desc;

    pmd_parser #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_bytes (in_bytes),
        .q_full   (q_full),
        .push     (push),
        .desc     (wr_desc)
    );

    pmd_desc_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_data  (wr_desc),
        .full     (q_full),
        .pop      (q_pop),
        .rd_valid (q_valid),
        .rd_data  (rd_desc)
    );

    pmd_emitter u_emitter (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (rd_desc),
        .q_pop   (q_pop),
        .events  (events)
    );

endmodule

>>> rtl/pmd_parser.sv
// Byte parser: header, record and origin framing, producing a descriptor for each byte that causes events.
module pmd_parser #(
    parameter int MAX_SLOTS = 9
) (
    input  logic           clk,
    input  logic           rst_n,
    pmd_in_if.sink         in_bytes,
    input  logic           q_full,
    output logic           push,
    output pmd_pkg::desc_t desc
);

    localparam int CNT_W = $clog2(MAX_SLOTS + 1);
    localparam pmd_pkg::mask_t ALL_MASK =
        pmd_pkg::mask_t'((33'd1 << MAX_SLOTS) - 33'd1);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_RECORD = 2'd1,
        PH_ORIGIN = 2'd2
    } phase_t;

    phase_t                 phase_reg,  phase_next;
    logic [4:0]             pos_reg,    pos_next;
    logic [23:0]            hdr_reg,    hdr_next;
    logic [CNT_W-1:0]       left_reg,   left_next;
    logic [7:0]             rslot_reg,  rslot_next;
    logic [MAX_SLOTS-1:0]   umask_reg,  umask_next;
    pmd_pkg::words_t        words_reg,  words_next;

    logic                   accept;
    logic [7:0]             b;
    logic                   ld_en;
    logic [4:0]             ld_pos;
    logic [2:0]             ld_idx;
    logic [1:0]             ld_lane;
    logic [4:0]             pos_inc;
    logic [MAX_SLOTS-1:0]   umask_upd;
    logic [CNT_W-1:0]       left_dec;

    assign in_bytes.ready = !q_full;
    assign accept         = in_bytes.valid && !q_full;
    assign b              = in_bytes.byte_value;
    assign pos_inc        = pos_reg + 5'd1;

    // Which payload byte (if any) this request writes into the word store
    always_comb
    begin
        ld_en  = 1'b0;
        ld_pos = pos_reg;
        if (accept && !in_bytes.mode)
        begin
            unique case (phase_reg)
                PH_RECORD:
                begin
                    ld_en  = (pos_reg != 5'd0);
                    ld_pos = pos_reg - 5'd1;
                end
                PH_ORIGIN:
                begin
                    ld_en  = 1'b1;
                    ld_pos = pos_reg;
                end
                default:
                begin
                    ld_en  = 1'b0;
                    ld_pos = pos_reg;
                end
            endcase
        end
    end

    // Word store update: lane 0 starts a fresh word, later lanes OR in
    assign ld_idx  = ld_pos[4:2];
    assign ld_lane = ld_pos[1:0];

    always_comb
    begin
        words_next = words_reg;
        if (ld_en && (ld_idx != 3'd7))
        begin
            if (ld_lane == 2'd0)
            begin
                words_next[ld_idx] = {24'd0, b};
            end
            else
            begin
                words_next[ld_idx][{ld_lane, 3'b000} +: 8] =
                    words_reg[ld_idx][{ld_lane, 3'b000} +: 8] | b;
            end
        end
    end

    // Framing state and descriptor
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        hdr_next   = hdr_reg;
        left_next  = left_reg;
        rslot_next = rslot_reg;
        umask_next = umask_reg;
        umask_upd  = umask_reg;
        left_dec   = left_reg;
        desc          = '0;
        desc.words    = words_next;

        if (accept)
        begin
            if (in_bytes.mode)
            begin
                // link closed: drop partial message, invalidate everything
                phase_next = PH_HEADER;
                pos_next   = '0;
                hdr_next   = '0;
                left_next  = '0;
                rslot_next = '0;
                umask_next = '0;
                desc.inv   = ALL_MASK;
            end
            else
            begin
                unique case (phase_reg)
                    PH_RECORD:
                    begin
                        if (pos_reg == 5'd0)
                        begin
                            rslot_next = b;
                        end
                        if (pos_inc >= pmd_pkg::RECORD_BYTES)
                        begin
                            pos_next = '0;
                            if (rslot_next < 8'(MAX_SLOTS))
                            begin
                                desc.upd      = 1'b1;
                                desc.upd_slot = rslot_next[3:0];
                                umask_upd     = umask_reg |
                                                (MAX_SLOTS'(1) << rslot_next[3:0]);
                            end
                            umask_next = umask_upd;
                            if (left_reg != '0)
                            begin
                                left_dec = left_reg - CNT_W'(1);
                            end
                            left_next = left_dec;
                            if (left_dec == '0)
                            begin
                                // end of batch: invalidate slots left untouched
                                desc.inv   = pmd_pkg::mask_t'(~umask_upd) & ALL_MASK;
                                umask_next = '0;
                                phase_next = PH_HEADER;
                            end
                        end
                        else
                        begin
                            pos_next = pos_inc;
                        end
                    end
                    PH_ORIGIN:
                    begin
                        if (pos_inc >= pmd_pkg::PAYLOAD_BYTES)
                        begin
                            pos_next    = '0;
                            desc.inv    = ALL_MASK;
                            desc.origin = 1'b1;
                            phase_next  = PH_HEADER;
                        end
                        else
                        begin
                            pos_next = pos_inc;
                        end
                    end
                    default:
                    begin
                        // header phase, also taken for the unused phase code
                        phase_next = PH_HEADER;
                        if (pos_reg < pmd_pkg::HEADER_LAST)
                        begin
                            hdr_next[{pos_reg[1:0], 3'b000} +: 8] =
                                hdr_reg[{pos_reg[1:0], 3'b000} +: 8] | b;
                            pos_next = pos_inc;
                        end
                        else
                        begin
                            pos_next = '0;
                            hdr_next = '0;
                            if ((hdr_reg[7:0] == pmd_pkg::HDR_MAGIC0) &&
                                (hdr_reg[15:8] == pmd_pkg::HDR_MAGIC1))
                            begin
                                priority if ((hdr_reg[23:16] == pmd_pkg::TYPE_POSE) &&
                                             (b != 8'd0) && (b <= 8'(MAX_SLOTS)))
                                begin
                                    left_next  = CNT_W'(b);
                                    umask_next = '0;
                                    phase_next = PH_RECORD;
                                end
                                else if (hdr_reg[23:16] == pmd_pkg::TYPE_RESET)
                                begin
                                    desc.inv = ALL_MASK;
                                end
                                else if (hdr_reg[23:16] == pmd_pkg::TYPE_ORIGIN)
                                begin
                                    phase_next = PH_ORIGIN;
                                end
                                else
                                begin
                                    phase_next = PH_HEADER;
                                end
                            end
                        end
                    end
                endcase
            end
        end
    end

    assign push = accept && (desc.upd || (desc.inv != '0) || desc.origin);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            pos_reg   <= '0;
            hdr_reg   <= '0;
            left_reg  <= '0;
            rslot_reg <= '0;
            umask_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            hdr_reg   <= hdr_next;
            left_reg  <= left_next;
            rslot_reg <= rslot_next;
            umask_reg <= umask_next;
        end
    end

    // Payload words
    always_ff @(posedge clk)
    begin
        words_reg <= words_next;
    end

    a_record_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_RECORD) |-> (left_reg != '0))
        else $error("record phase with no records left");

    a_record_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_RECORD) |-> (pos_reg < pmd_pkg::RECORD_BYTES))
        else $error("record byte position out of range");

    a_origin_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ORIGIN) |-> (pos_reg < pmd_pkg::PAYLOAD_BYTES))
        else $error("origin byte position out of range");

    a_header_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HEADER) |-> (pos_reg <= pmd_pkg::HEADER_LAST))
        else $error("header byte position out of range");

endmodule

>>> rtl/pmd_desc_fifo.sv
// Small descriptor queue that absorbs invalidate bursts at message ends.
module pmd_desc_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pmd_pkg::desc_t wr_data,
    output logic           full,
    input  logic           pop,
    output logic           rd_valid,
    output pmd_pkg::desc_t rd_data
);

    localparam int CNT_W = $clog2(pmd_pkg::QUEUE_DEPTH + 1);

    pmd_pkg::desc_t                store [pmd_pkg::QUEUE_DEPTH];
    logic [pmd_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [pmd_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]              count_reg,  count_next;
    logic                          do_push;
    logic                          do_pop;

    assign full     = (count_reg == CNT_W'(pmd_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = store[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && rd_valid;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + pmd_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + pmd_pkg::QPTR_W'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(pmd_pkg::QUEUE_DEPTH))
        else $error("queue occupancy above depth");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> rd_valid)
        else $error("pop from empty queue");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

endmodule

>>> rtl/pmd_emitter.sv
// Event emitter: expands one descriptor into result events, one per cycle while the event sink is ready.
module pmd_emitter (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  pmd_pkg::desc_t q_data,
    output logic           q_pop,
    pmd_out_if.source      events
);

    // Working descriptor
    logic              busy_reg,  busy_next;
    logic              upd_reg,   upd_next;
    logic [3:0]        uslot_reg, uslot_next;
    pmd_pkg::mask_t    inv_reg,   inv_next;
    logic              org_reg,   org_next;
    pmd_pkg::words_t   wwords_reg, wwords_next;

    // Output register
    logic              ov_reg,    ov_next;
    logic [3:0]        oslot_reg, oslot_next;
    pmd_pkg::kind_t    okind_reg, okind_next;
    pmd_pkg::words_t   owords_reg, owords_next;
    logic              olast_reg, olast_next;

    logic              advance;
    pmd_pkg::kind_t    sel_kind;
    logic [3:0]        sel_slot;
    logic              sel_last;
    pmd_pkg::mask_t    inv_after;

    assign advance = !ov_reg || events.ready;

    // Pick the next event of the working descriptor
    always_comb
    begin
        inv_after = inv_reg;
        if (upd_reg)
        begin
            sel_kind = pmd_pkg::KIND_UPDATE;
            sel_slot = uslot_reg;
            sel_last = (inv_reg == '0) && !org_reg;
        end
        else if (inv_reg != '0)
        begin
            sel_kind  = pmd_pkg::KIND_INVALIDATE;
            sel_slot  = pmd_pkg::lowest_index(inv_reg);
            inv_after = inv_reg & (inv_reg - pmd_pkg::mask_t'(1));
            sel_last  = (inv_after == '0) && !org_reg;
        end
        else
        begin
            sel_kind = pmd_pkg::KIND_ORIGIN;
            sel_slot = 4'd0;
            sel_last = 1'b1;
        end
    end

    // Take the next descriptor as soon as the current one is spent
    assign q_pop = q_valid && (!busy_reg || (advance && sel_last));

    always_comb
    begin
        busy_next   = busy_reg;
        upd_next    = upd_reg;
        uslot_next  = uslot_reg;
        inv_next    = inv_reg;
        org_next    = org_reg;
        wwords_next = wwords_reg;
        ov_next     = ov_reg;
        oslot_next  = oslot_reg;
        okind_next  = okind_reg;
        owords_next = owords_reg;
        olast_next  = olast_reg;

        if (advance)
        begin
            ov_next = busy_reg;
            if (busy_reg)
            begin
                oslot_next  = sel_slot;
                okind_next  = sel_kind;
                olast_next  = sel_last;
                owords_next = (sel_kind == pmd_pkg::KIND_INVALIDATE) ? '0 : wwords_reg;
                upd_next    = 1'b0;
                inv_next    = upd_reg ? inv_reg : inv_after;
                org_next    = (upd_reg || (inv_reg != '0)) ? org_reg : 1'b0;
                busy_next   = !sel_last;
            end
        end

        if (q_pop)
        begin
            busy_next   = 1'b1;
            upd_next    = q_data.upd;
            uslot_next  = q_data.upd_slot;
            inv_next    = q_data.inv;
            org_next    = q_data.origin;
            wwords_next = q_data.words;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            upd_reg  <= 1'b0;
            inv_reg  <= '0;
            org_reg  <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            upd_reg  <= upd_next;
            inv_reg  <= inv_next;
            org_reg  <= org_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        uslot_reg  <= uslot_next;
        wwords_reg <= wwords_next;
        oslot_reg  <= oslot_next;
        okind_reg  <= okind_next;
        owords_reg <= owords_next;
        olast_reg  <= olast_next;
    end

    assign events.valid      = ov_reg;
    assign events.slot       = oslot_reg;
    assign events.event_kind = okind_reg;
    assign events.pos_x      = owords_reg[0];
    assign events.pos_y      = owords_reg[1];
    assign events.pos_z      = owords_reg[2];
    assign events.rot_w      = owords_reg[3];
    assign events.rot_x      = owords_reg[4];
    assign events.rot_y      = owords_reg[5];
    assign events.rot_z      = owords_reg[6];
    assign events.last       = olast_reg;

    a_busy_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (upd_reg || (inv_reg != '0) || org_reg))
        else $error("working descriptor busy with nothing pending");

    a_idle_no_work: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (!upd_reg && (inv_reg == '0) && !org_reg))
        else $error("pending events without a working descriptor");

    a_origin_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && (okind_reg == pmd_pkg::KIND_ORIGIN)) |-> olast_reg)
        else $error("origin event not marked last");

endmodule

>>> tb/sv/pmd_tb_pkg.sv
// Event record and parser mirror used to predict and check the deframer's events.
package pmd_tb_pkg;

    import pmd_pkg::*;

    // Slot count the block is built with in this bench
    localparam int SLOT_COUNT = 9;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_RECORD = 2'd1,
        PH_ORIGIN = 2'd2
    } parse_phase_t;

    typedef struct {
        logic [3:0] slot;
        kind_t      kind;
        words_t     words;
        logic       last;
    } pose_event_t;

    // Tracks the parser state byte by byte, queues the events each request
    // should produce and compares the block's events against them.
    class deframer_mirror;
        pose_event_t           due_events[$];
        int                    faults;
        int                    requests;
        int                    closes;
        int                    kind_counts[3];
        string                 word_names[7];

        parse_phase_t          phase;
        logic [4:0]            byte_pos;
        logic [23:0]           header_bytes;
        logic [3:0]            records_left;
        logic [7:0]            record_slot;
        words_t                value_words;
        logic [SLOT_COUNT-1:0] updated_mask;

        function new();
            faults = 0;
            requests = 0;
            closes = 0;
            kind_counts = '{0, 0, 0};
            word_names = '{"pos_x", "pos_y", "pos_z", "rot_w", "rot_x", "rot_y", "rot_z"};
            value_words = '0;
            restart();
        endfunction

        function void restart();
            phase = PH_HEADER;
            byte_pos = '0;
            header_bytes = '0;
            records_left = '0;
            record_slot = '0;
            updated_mask = '0;
        endfunction

        function void add_event(logic [3:0] slot, kind_t kind, words_t words);
            pose_event_t ev;
            ev.slot = slot;
            ev.kind = kind;
            ev.words = words;
            ev.last = 1'b0;
            due_events.push_back(ev);
        endfunction

        function void invalidate_all();
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                add_event(4'(i), KIND_INVALIDATE, '0);
            end
        endfunction

        // Little-endian word assembly; byte 0 of a word starts it afresh
        function void load_byte(logic [4:0] pos, logic [7:0] b);
            if (pos[1:0] == 2'd0)
            begin
                value_words[pos[4:2]] = 32'(b);
            end
            else
            begin
                value_words[pos[4:2]] = value_words[pos[4:2]] | (32'(b) << (8 * pos[1:0]));
            end
        endfunction

        function void note_request(logic link_closed, logic [7:0] b);
            int          first;
            pose_event_t tail;
            logic [7:0]  magic0;
            logic [7:0]  magic1;
            logic [7:0]  msg_type;

            first = due_events.size();
            requests++;
            if (link_closed)
            begin
                // Partial message dropped, every slot invalidated
                closes++;
                restart();
                invalidate_all();
            end
            else if (phase == PH_RECORD)
            begin
                if (byte_pos == 5'd0)
                begin
                    record_slot = b;
                end
                else
                begin
                    load_byte(byte_pos - 5'd1, b);
                end
                byte_pos++;
                if (byte_pos >= RECORD_BYTES)
                begin
                    byte_pos = '0;
                    if (record_slot < SLOT_COUNT)
                    begin
                        add_event(record_slot[3:0], KIND_UPDATE, value_words);
                        updated_mask[record_slot] = 1'b1;
                    end
                    if (records_left > 0)
                    begin
                        records_left--;
                    end
                    // Batch end: slots no record touched go invalid
                    if (records_left == 0)
                    begin
                        for (int i = 0; i < SLOT_COUNT; i++)
                        begin
                            if (!updated_mask[i])
                            begin
                                add_event(4'(i), KIND_INVALIDATE, '0);
                            end
                        end
                        updated_mask = '0;
                        phase = PH_HEADER;
                    end
                end
            end
            else if (phase == PH_ORIGIN)
            begin
                load_byte(byte_pos, b);
                byte_pos++;
                if (byte_pos >= PAYLOAD_BYTES)
                begin
                    byte_pos = '0;
                    invalidate_all();
                    add_event(4'd0, KIND_ORIGIN, value_words);
                    phase = PH_HEADER;
                end
            end
            else
            begin
                phase = PH_HEADER;
                if (byte_pos < HEADER_LAST)
                begin
                    header_bytes = header_bytes | (24'(b) << (8 * byte_pos));
                    byte_pos++;
                end
                else
                begin
                    // Fourth header byte: decode the whole header
                    magic0 = header_bytes[7:0];
                    magic1 = header_bytes[15:8];
                    msg_type = header_bytes[23:16];
                    byte_pos = '0;
                    header_bytes = '0;
                    if (magic0 == HDR_MAGIC0 && magic1 == HDR_MAGIC1)
                    begin
                        if (msg_type == TYPE_POSE && b >= 8'd1 && b <= SLOT_COUNT)
                        begin
                            records_left = b[3:0];
                            updated_mask = '0;
                            phase = PH_RECORD;
                        end
                        else if (msg_type == TYPE_RESET)
                        begin
                            invalidate_all();
                        end
                        else if (msg_type == TYPE_ORIGIN)
                        begin
                            phase = PH_ORIGIN;
                        end
                    end
                end
            end

            // Flag the final event of this request
            if (due_events.size() > first)
            begin
                tail = due_events.pop_back();
                tail.last = 1'b1;
                due_events.push_back(tail);
            end
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] seen, time stamp);
            if (want !== seen)
            begin
                faults++;
                $display("%0d ns: %s expected %h, got %h", stamp, field, want, seen);
            end
        endfunction

        function void check_event(pose_event_t got, time stamp);
            pose_event_t want;

            if (got.kind <= KIND_ORIGIN)
            begin
                kind_counts[got.kind]++;
            end
            if (due_events.size() == 0)
            begin
                faults++;
                $display("%0d ns: expected no event, got slot %0d kind %0d",
                         stamp, got.slot, got.kind);
            end
            else
            begin
                want = due_events.pop_front();
                report("slot", 32'(want.slot), 32'(got.slot), stamp);
                report("event_kind", 32'(want.kind), 32'(got.kind), stamp);
                for (int i = 0; i < 7; i++)
                begin
                    report(word_names[i], want.words[i], got.words[i], stamp);
                end
                report("last", 32'(want.last), 32'(got.last), stamp);
            end
        endfunction
    endclass

endpackage

>>> tb/sv/pose_message_deframer_tb.sv
// Self-checking bench for the pose message deframer: framed byte stream in, events checked out.
module pose_message_deframer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pmd_pkg::*;
    import pmd_tb_pkg::*;

    localparam int         STALL_LIMIT = 5000;
    localparam int         DRAIN_CYCLES = 20;
    localparam logic [7:0] TYPE_UNUSED = 8'h00;

    logic clk;
    logic rst_n;
    int   src_idle_pct;
    int   snk_idle_pct;
    int   stall_cycles;

    bit [7:0]       msg_bytes[$];
    deframer_mirror mirror = new();

    pmd_in_if  in_bytes();
    pmd_out_if events();

    pose_message_deframer #(
        .MAX_SLOTS (SLOT_COUNT)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_bytes (in_bytes),
        .events   (events)
    );

    // 50 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Event sink back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            events.ready <= 1'b0;
        end
        else
        begin
            events.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Accepted requests feed the mirror, accepted events are checked; watchdog
    always @(posedge clk)
    begin
        pose_event_t seen;
        bit          moved;

        moved = 1'b0;
        if (rst_n && in_bytes.valid && in_bytes.ready)
        begin
            moved = 1'b1;
            mirror.note_request(in_bytes.mode, in_bytes.byte_value);
        end
        if (rst_n && events.valid && events.ready)
        begin
            moved = 1'b1;
            seen.slot = events.slot;
            seen.kind = kind_t'(events.event_kind);
            seen.words = {events.rot_z, events.rot_y, events.rot_x, events.rot_w,
                          events.pos_z, events.pos_y, events.pos_x};
            seen.last = events.last;
            mirror.check_event(seen, $time);
        end
        if (rst_n)
        begin
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0d ns: no progress for %0d cycles, %0d events outstanding",
                         $time, STALL_LIMIT, mirror.due_events.size());
                $display("pose_message_deframer: mismatch");
                $finish;
            end
        end
    end

    // Message builders, little-endian on the wire
    function automatic void add_header(bit [7:0] m0, bit [7:0] m1, bit [7:0] msg_type,
                                       bit [7:0] count);
        msg_bytes.push_back(m0);
        msg_bytes.push_back(m1);
        msg_bytes.push_back(msg_type);
        msg_bytes.push_back(count);
    endfunction

    function automatic bit [31:0] random_word();
        case ($urandom_range(9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic void add_words();
        bit [31:0] w;
        for (int i = 0; i < 7; i++)
        begin
            w = random_word();
            for (int k = 0; k < 4; k++)
            begin
                msg_bytes.push_back(w[8*k +: 8]);
            end
        end
    endfunction

    // Mostly live slots, some out of range
    function automatic bit [7:0] random_slot();
        if ($urandom_range(4) == 0)
        begin
            return 8'($urandom_range(SLOT_COUNT, 255));
        end
        return 8'($urandom_range(SLOT_COUNT - 1));
    endfunction

    function automatic void add_pose(int count);
        add_header(HDR_MAGIC0, HDR_MAGIC1, TYPE_POSE, 8'(count));
        for (int r = 0; r < count; r++)
        begin
            msg_bytes.push_back(random_slot());
            add_words();
        end
    endfunction

    function automatic void add_origin();
        add_header(HDR_MAGIC0, HDR_MAGIC1, TYPE_ORIGIN, 8'($urandom));
        add_words();
    endfunction

    // Headers the parser must swallow without effect
    function automatic void add_noise();
        bit [7:0] m0;
        bit [7:0] m1;
        case ($urandom_range(2))
            0:
            begin
                m0 = 8'($urandom);
                m1 = 8'($urandom);
                if (m0 == HDR_MAGIC0 && m1 == HDR_MAGIC1)
                begin
                    m0 = m0 ^ 8'h01;
                end
                add_header(m0, m1, 8'($urandom_range(TYPE_POSE, TYPE_ORIGIN)), 8'($urandom));
            end
            1:
            begin
                add_header(HDR_MAGIC0, HDR_MAGIC1,
                           $urandom_range(1) ? TYPE_UNUSED : 8'($urandom_range(4, 255)),
                           8'($urandom));
            end
            default:
            begin
                add_header(HDR_MAGIC0, HDR_MAGIC1, TYPE_POSE,
                           $urandom_range(1) ? 8'h00 : 8'($urandom_range(SLOT_COUNT + 1, 255)));
            end
        endcase
    endfunction

    // One request, held until accepted
    task automatic send_request(bit link_closed, bit [7:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_bytes.valid <= 1'b0;
            @(posedge clk);
        end
        in_bytes.valid <= 1'b1;
        in_bytes.mode <= link_closed;
        in_bytes.byte_value <= b;
        do
        begin
            @(posedge clk);
        end
        while (!in_bytes.ready);
    endtask

    task automatic send_message();
        foreach (msg_bytes[i])
        begin
            send_request(1'b0, msg_bytes[i]);
        end
        msg_bytes.delete();
    endtask

    // Well-formed messages with random content, plus noise and cut-off messages
    task automatic random_message(output int sent);
        int pick;
        int keep;
        bit cut;

        cut = 1'b0;
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            add_pose(($urandom_range(9) == 0) ? $urandom_range(3, SLOT_COUNT)
                                               : $urandom_range(1, 2));
        end
        else if (pick < 62)
        begin
            add_origin();
        end
        else if (pick < 70)
        begin
            add_header(HDR_MAGIC0, HDR_MAGIC1, TYPE_RESET, 8'($urandom));
        end
        else if (pick < 80)
        begin
            add_noise();
        end
        else
        begin
            // Link drops somewhere inside a message, or between messages
            cut = 1'b1;
            if ($urandom_range(1))
            begin
                add_pose($urandom_range(1, 2));
            end
            else
            begin
                add_origin();
            end
            keep = $urandom_range(msg_bytes.size() - 1);
            while (msg_bytes.size() > keep)
            begin
                void'(msg_bytes.pop_back());
            end
        end
        sent = msg_bytes.size() + cut;
        send_message();
        if (cut)
        begin
            send_request(1'b1, 8'($urandom));
        end
    endtask

    task automatic random_phase(int budget);
        int total;
        int sent;
        total = 0;
        while (total < budget)
        begin
            random_message(sent);
            total += sent;
        end
    endtask

    // Short directed sequence: header corner cases and link close
    task automatic directed_headers();
        add_header(HDR_MAGIC0, HDR_MAGIC1, TYPE_RESET, 8'hFF);
        add_header(HDR_MAGIC0 ^ 8'h01, HDR_MAGIC1, TYPE_POSE, 8'h01);
        add_header(HDR_MAGIC0, HDR_MAGIC1, TYPE_UNUSED, 8'h01);
        add_header(HDR_MAGIC0, HDR_MAGIC1, TYPE_POSE, 8'h00);
        add_header(HDR_MAGIC0, HDR_MAGIC1, TYPE_POSE, 8'(SLOT_COUNT + 1));
        send_message();
        send_request(1'b1, 8'h00);
        msg_bytes.push_back(HDR_MAGIC0);
        msg_bytes.push_back(HDR_MAGIC1);
        send_message();
        send_request(1'b1, 8'hFF);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_bytes.valid = 1'b0;
        in_bytes.mode = 1'b0;
        in_bytes.byte_value = 8'h00;
        stall_cycles = 0;
        src_idle_pct = 7;
        snk_idle_pct = 65;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Light sender gaps, heavy receiver stalls
        directed_headers();
        random_phase(70);

        // Reversed
        src_idle_pct = 65;
        snk_idle_pct = 7;
        random_phase(70);

        // Full rate both sides
        src_idle_pct = 0;
        snk_idle_pct = 0;
        random_phase(70);
        in_bytes.valid <= 1'b0;

        while (mirror.due_events.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests (%0d link closes) under three idle mixes.",
                 mirror.requests, mirror.closes);
        $display("Checked %0d updates, %0d invalidates, %0d origin events; %0d field errors.",
                 mirror.kind_counts[KIND_UPDATE], mirror.kind_counts[KIND_INVALIDATE],
                 mirror.kind_counts[KIND_ORIGIN], mirror.faults);
        if (mirror.faults == 0 && mirror.due_events.size() == 0)
        begin
            $display("pose_message_deframer: match");
        end
        else
        begin
            $display("pose_message_deframer: mismatch");
        end
        $finish;
    end

endmodule
